### src/ecbui_pkg.sv
// ----------------------------------------------------------------------------
// ecbui_pkg
// Shared constants for the rotary encoder menu cursor block: register map,
// register reset values and default sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package ecbui_pkg;

  // sizing defaults
  localparam int DefVisibleRows = 3;
  localparam int DefMaxDevices  = 127;

  // field widths
  localparam int CountW = 7;
  localparam int StampW = 32;
  localparam int CfgW   = 16;

  // configuration port
  localparam int AddrW = 3;
  localparam int DataW = 32;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_HOLD_MS  = 1'b0,
    REG_CLICK_MS = 1'b1
  } reg_index_t;

  localparam logic [CfgW-1:0] HoldMsReset  = 16'd1000;
  localparam logic [CfgW-1:0] ClickMsReset = 16'd50;

  // one result item
  typedef struct packed {
    logic [CountW-1:0] cursor_index;
    logic [CountW-1:0] scroll_top;
    logic              redraw;
    logic              scan_request;
    logic              blink_request;
  } result_t;

endpackage

`default_nettype wire

### src/encoder_cursor_button_ui_core.sv
// ----------------------------------------------------------------------------
// encoder_cursor_button_ui_core
// Rotary encoder and push switch handling for a menu cursor with a
// three-row scroll window, click and long-press requests.
// ----------------------------------------------------------------------------
// Each accepted sample of the encoder pins, switch, timestamp and device count
// yields exactly one result, in the result register or, while that is held, in
// the one-entry skid register; a new sample can be taken every cycle while
// item_stall is low. All edge detection, the press timer compare and the cursor
// clamp run in one combinational pass from the state registers into the result
// register. With the skid, a result held by result_stall costs one more accepted
// sample before item_stall rises. item_stall comes from a register only. hold_ms
// and click_ms (minimum press time for a click) are written over the APB port at
// byte addresses 0 and 4, by the user only while no sample is in flight (the block does not enforce this).
`default_nettype none

module encoder_cursor_button_ui_core
#(
  parameter int VISIBLE_ROWS = ecbui_pkg::DefVisibleRows,
  parameter int MAX_DEVICES  = ecbui_pkg::DefMaxDevices
)
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  // sample channel
  input  wire logic                        item_valid,
  output logic                             item_stall,
  input  wire logic                        clk_level,
  input  wire logic                        dt_level,
  input  wire logic                        switch_level,
  input  wire logic [ecbui_pkg::StampW-1:0] now_ms,
  input  wire logic [ecbui_pkg::CountW-1:0] device_count,
  // result channel
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output logic [ecbui_pkg::CountW-1:0]     cursor_index,
  output logic [ecbui_pkg::CountW-1:0]     scroll_top,
  output logic                             redraw,
  output logic                             scan_request,
  output logic                             blink_request,
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ecbui_pkg::AddrW-1:0] paddr,
  input  wire logic [ecbui_pkg::DataW-1:0] pwdata,
  output logic [ecbui_pkg::DataW-1:0]      prdata,
  output logic                             pready
);
  import ecbui_pkg::*;

  localparam logic [CountW-1:0] MaxLimit = CountW'(MAX_DEVICES);
  localparam logic [CountW:0]   Rows     = (CountW+1)'(VISIBLE_ROWS);
  localparam logic [CountW:0]   RowsLess = (CountW+1)'(VISIBLE_ROWS - 1);

  // configuration registers
  logic [CfgW-1:0] hold_ms;
  logic [CfgW-1:0] click_ms;
  reg_index_t      cfg_sel;
  logic            cfg_write;

  // item state
  logic              prev_clk;
  logic              prev_switch;
  logic [StampW-1:0] press_stamp;
  logic              hold_done;
  logic [CountW-1:0] cursor_reg;
  logic [CountW-1:0] scroll_reg;

  // output register and skid
  result_t result;
  result_t skid;
  logic    skid_valid;
  result_t result_next;

  logic accept;
  logic take;

  // per-item logic
  logic              falling;
  logic              press;
  logic              release_edge;
  logic [StampW-1:0] press_stamp_next;
  logic              hold_base;
  logic              hold_done_next;
  logic [StampW-1:0] elapsed;
  logic              fire;
  logic              click;
  logic              move;
  logic [CountW-1:0] limit;
  logic [CountW:0]   cur_wide;
  logic [CountW:0]   stepped;
  logic [CountW:0]   clamped;
  logic [CountW:0]   scroll_wide;
  logic [CountW:0]   scroll_moved;
  logic [CountW-1:0] cursor_reg_next;
  logic [CountW-1:0] scroll_reg_next;

  // ---------------------------------------------------------------- config
  assign pready    = 1'b1;
  assign cfg_sel   = reg_index_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ms  <= HoldMsReset;
      click_ms <= ClickMsReset;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_HOLD_MS:  hold_ms  <= pwdata[CfgW-1:0];
        REG_CLICK_MS: click_ms <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_HOLD_MS:  prdata = {{(DataW-CfgW){1'b0}}, hold_ms};
      REG_CLICK_MS: prdata = {{(DataW-CfgW){1'b0}}, click_ms};
      default:      prdata = '0;
    endcase
  end

  // ------------------------------------------------------------- handshake
  assign item_stall = skid_valid;
  assign accept     = item_valid && !skid_valid;
  assign take       = result_valid && !result_stall;

  // ---------------------------------------------------------- item compute
  always_comb begin
    falling      = !clk_level && prev_clk;
    press        = !switch_level && prev_switch;
    release_edge = switch_level && !prev_switch;

    // a press restarts the timer in the same sample
    press_stamp_next = press ? now_ms : press_stamp;
    hold_base        = press ? 1'b0 : hold_done;
    elapsed          = now_ms - press_stamp_next;

    fire  = !switch_level && !hold_base && (elapsed >= {{(StampW-CfgW){1'b0}}, hold_ms});
    click = release_edge && !hold_base && (device_count != '0) &&
            (elapsed >= {{(StampW-CfgW){1'b0}}, click_ms});
    hold_done_next = fire ? 1'b1 : hold_base;

    move  = falling && !fire && !click && (device_count != '0);
    limit = (device_count > MaxLimit) ? MaxLimit : device_count;

    cur_wide = {1'b0, cursor_reg};
    if (dt_level) begin
      stepped = cur_wide + 1'b1;
    end else if (cursor_reg == '0) begin
      stepped = '0;
    end else begin
      stepped = cur_wide - 1'b1;
    end
    // clamp also catches a cursor left past a shrunken list
    clamped = (stepped >= {1'b0, limit}) ? ({1'b0, limit} - 1'b1) : stepped;

    scroll_wide = {1'b0, scroll_reg};
    if (clamped < scroll_wide) begin
      scroll_moved = clamped;
    end else if (clamped >= scroll_wide + Rows) begin
      scroll_moved = clamped - RowsLess;
    end else begin
      scroll_moved = scroll_wide;
    end

    cursor_reg_next = move ? clamped[CountW-1:0] : cursor_reg;
    scroll_reg_next = move ? scroll_moved[CountW-1:0] : scroll_reg;

    result_next.cursor_index  = cursor_reg_next;
    result_next.scroll_top    = scroll_reg_next;
    result_next.redraw        = move;
    result_next.scan_request  = fire;
    result_next.blink_request = click;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_clk    <= 1'b1;
      prev_switch <= 1'b1;
      press_stamp <= '0;
      hold_done   <= 1'b0;
      cursor_reg  <= '0;
      scroll_reg  <= '0;
    end else if (accept) begin
      prev_clk    <= clk_level;
      prev_switch <= switch_level;
      press_stamp <= press_stamp_next;
      hold_done   <= hold_done_next;
      cursor_reg  <= cursor_reg_next;
      scroll_reg  <= scroll_reg_next;
    end
  end

  // ------------------------------------------------------ result and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (result_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        result_valid <= 1'b1;
      end
    end else if (take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        result <= skid;
      end
    end else if (accept) begin
      if (result_valid && !take) begin
        skid <= result_next;
      end else begin
        result <= result_next;
      end
    end
  end

  assign cursor_index  = result.cursor_index;
  assign scroll_top    = result.scroll_top;
  assign redraw        = result.redraw;
  assign scan_request  = result.scan_request;
  assign blink_request = result.blink_request;

`ifndef ASSERT_OFF
  // skid only fills behind a held result
  a_skid_behind_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid holds data with output register empty");

  // a fired hold drops the step, a click needs a release
  a_requests_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(scan_request && blink_request) &&
                     !(redraw && (scan_request || blink_request)))
    else $error("redraw, scan and blink overlap in one result");

  // cursor stays inside the clamp range
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, cursor_reg} < (CountW+1)'(MAX_DEVICES))
    else $error("cursor beyond device limit");

  // window always contains the cursor
  a_window: assert property (@(posedge clk) disable iff (rst)
    (scroll_reg <= cursor_reg) && ({1'b0, cursor_reg} < {1'b0, scroll_reg} + Rows))
    else $error("scroll window does not contain cursor");

  // a full skid drains into the output register on a transfer
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !result_stall |=> result_valid && !skid_valid)
    else $error("skid not drained after transfer");
`endif

endmodule

`default_nettype wire
